/* sv/metropolis_tensor_spin_update_macros.svh */
// Assertion macros used by the spin update sequencer (mts_seq).
// Each macro assumes clk and arst_n are in scope at the point of use.
`ifndef METROPOLIS_TENSOR_SPIN_UPDATE_MACROS_SVH
`define METROPOLIS_TENSOR_SPIN_UPDATE_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mts_pkg.sv */
// Package for the Metropolis tensor spin update block.
// Types, constants and helper functions shared by all modules; no dependencies.
`timescale 1ns / 1ps

package mts_pkg;

	// default sizes
	localparam int SITES_DEF      = 4096;
	localparam int NEIGHBOURS_DEF = 32;
	localparam int TENSORS_DEF    = 32;

	// fixed point format of spins
	localparam int SPIN_FRAC_BITS = 14;
	localparam int SPIN_W         = 16;
	localparam int PROD_SH_W      = SPIN_W + 2;

	localparam int COMPONENTS = 9;
	localparam int AXES       = 3;

	// widest index fields over the legal parameter ranges
	localparam int SITE_MAX_W = 16;
	localparam int NT_MAX_AW  = 22;
	localparam int TEN_MAX_W  = 6;
	localparam int TS_MAX_AW  = 10;

	localparam int COEF_W = 24;
	localparam int CFG_W  = 24;
	localparam int DE_W   = 48;
	localparam int SUM_W  = 28;
	localparam int ACC_W  = 63;
	localparam int WIDE_W = 64;

	// shared multiplier operand widths
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 19;
	localparam int MUL_P_W = 45;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	localparam logic signed [WIDE_W-1:0] ACC_LIM = 64'sd1 <<< 61;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANISO   = 3'd4;

	typedef enum logic [1:0] {
		OP_NBR_LOAD   = 2'd0,
		OP_TEN_LOAD   = 2'd1,
		OP_SPIN_RESET = 2'd2,
		OP_TRIAL      = 2'd3
	} op_t;

	typedef struct packed {
		logic        [CFG_W-1:0] beta;
		logic signed [CFG_W-1:0] fx;
		logic signed [CFG_W-1:0] fy;
		logic signed [CFG_W-1:0] fz;
		logic signed [CFG_W-1:0] aniso;
	} cfg_t;

	typedef struct packed {
		logic        [1:0]        op;
		logic        [11:0]       site;
		logic        [4:0]        slot;
		logic        [11:0]       nbr_site;
		logic        [4:0]        ten_idx;
		logic        [3:0]        comp;
		logic signed [COEF_W-1:0] coef;
		logic signed [SPIN_W-1:0] tx;
		logic signed [SPIN_W-1:0] ty;
		logic signed [SPIN_W-1:0] tz;
		logic        [15:0]       rnd;
	} item_t;

	typedef struct packed {
		logic                    accepted;
		logic signed [DE_W-1:0]  de;
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sz;
	} res_t;

	// memory requests from the sequencer
	typedef struct packed {
		logic                     nt_we;
		logic [NT_MAX_AW-1:0]     nt_waddr;
		logic [SITE_MAX_W-1:0]    nt_site;
		logic [TEN_MAX_W-1:0]     nt_ten;
		logic [NT_MAX_AW-1:0]     nt_raddr;
		logic                     ts_we;
		logic [TS_MAX_AW-1:0]     ts_waddr;
		logic signed [COEF_W-1:0] ts_coef;
		logic [TS_MAX_AW-1:0]     ts_raddr;
		logic                     sp_we;
		logic [SITE_MAX_W-1:0]    sp_waddr;
		logic [3*SPIN_W-1:0]      sp_wdata;
		logic [SITE_MAX_W-1:0]    sp_raddr;
	} mem_req_t;

	// registered read data
	typedef struct packed {
		logic [SITE_MAX_W-1:0]    nt_site;
		logic [TEN_MAX_W-1:0]     nt_ten;
		logic signed [COEF_W-1:0] ts_coef;
		logic [3*SPIN_W-1:0]      sp_data;
	} mem_rsp_t;

	// clamp to the energy accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (v > ACC_LIM)
			r = ACC_LIM;
		else if (v < -ACC_LIM)
			r = -ACC_LIM;
		return ACC_W'(r);
	endfunction

	// round(65536 * 2^(-k/16)), first entry held at full scale
	function automatic logic [15:0] pow2_frac(input logic [3:0] k);
		logic [15:0] v;
		unique case (k)
			4'd0:  v = 16'd65535;
			4'd1:  v = 16'd62757;
			4'd2:  v = 16'd60097;
			4'd3:  v = 16'd57549;
			4'd4:  v = 16'd55109;
			4'd5:  v = 16'd52773;
			4'd6:  v = 16'd50535;
			4'd7:  v = 16'd48393;
			4'd8:  v = 16'd46341;
			4'd9:  v = 16'd44376;
			4'd10: v = 16'd42495;
			4'd11: v = 16'd40693;
			4'd12: v = 16'd38968;
			4'd13: v = 16'd37316;
			4'd14: v = 16'd35734;
			4'd15: v = 16'd34219;
		endcase
		return v;
	endfunction

endpackage

/* sv/mts_mac.sv */
// Shared signed multiplier with a registered product.
// Depends on mts_pkg for operand widths.
`timescale 1ns / 1ps

module mts_mac (
	input  logic                                 clk,
	input  logic signed [mts_pkg::MUL_A_W-1:0]   a,
	input  logic signed [mts_pkg::MUL_B_W-1:0]   b,
	output logic signed [mts_pkg::MUL_P_W-1:0]   prod_s1
);

	// operands widened before the multiply so the product keeps all bits
	always_ff @(posedge clk) begin
		prod_s1 <= mts_pkg::MUL_P_W'(a) * mts_pkg::MUL_P_W'(b);
	end

endmodule

/* sv/mts_store.sv */
// Neighbour table, tensor store and spin store memories.
// Depends on mts_pkg for the request and response structs.
`timescale 1ns / 1ps

module mts_store #(
	parameter int SITES      = mts_pkg::SITES_DEF,
	parameter int NEIGHBOURS = mts_pkg::NEIGHBOURS_DEF,
	parameter int TENSORS    = mts_pkg::TENSORS_DEF
) (
	input  logic              clk,
	input  mts_pkg::mem_req_t req,
	output mts_pkg::mem_rsp_t rsp
);

	localparam int NT_DEPTH = SITES * NEIGHBOURS;
	localparam int NT_AW    = $clog2(NT_DEPTH);
	localparam int TS_DEPTH = TENSORS * mts_pkg::COMPONENTS;
	localparam int TS_AW    = $clog2(TS_DEPTH);
	localparam int SITE_W   = $clog2(SITES);
	localparam int TEN_W    = (TENSORS > 1) ? $clog2(TENSORS) : 1;
	localparam int SP_W     = 3 * mts_pkg::SPIN_W;

	logic [SITE_W+TEN_W-1:0]          nbr_mem [NT_DEPTH];
	logic signed [mts_pkg::COEF_W-1:0] ten_mem [TS_DEPTH];
	logic [SP_W-1:0]                  spin_mem [SITES];

	logic [SITE_W+TEN_W-1:0]           nbr_rd_q;
	logic signed [mts_pkg::COEF_W-1:0] ten_rd_q;
	logic [SP_W-1:0]                   spin_rd_q;

	// neighbour slot: site and tensor number
	always_ff @(posedge clk) begin
		if (req.nt_we)
			nbr_mem[NT_AW'(req.nt_waddr)] <= {SITE_W'(req.nt_site), TEN_W'(req.nt_ten)};
		nbr_rd_q <= nbr_mem[NT_AW'(req.nt_raddr)];
	end

	// tensor coefficients
	always_ff @(posedge clk) begin
		if (req.ts_we)
			ten_mem[TS_AW'(req.ts_waddr)] <= req.ts_coef;
		ten_rd_q <= ten_mem[TS_AW'(req.ts_raddr)];
	end

	// spins, packed x y z
	always_ff @(posedge clk) begin
		if (req.sp_we)
			spin_mem[SITE_W'(req.sp_waddr)] <= req.sp_wdata;
		spin_rd_q <= spin_mem[SITE_W'(req.sp_raddr)];
	end

	assign rsp.nt_site = mts_pkg::SITE_MAX_W'(nbr_rd_q[SITE_W+TEN_W-1:TEN_W]);
	assign rsp.nt_ten  = mts_pkg::TEN_MAX_W'(nbr_rd_q[TEN_W-1:0]);
	assign rsp.ts_coef = ten_rd_q;
	assign rsp.sp_data = spin_rd_q;

endmodule

/* sv/mts_seq.sv */
// Sequencer: handshake, table loads, spin clearing sweep, trial energy walk,
// acceptance test and result register. Depends on mts_pkg and the macro header.
`timescale 1ns / 1ps
`include "metropolis_tensor_spin_update_macros.svh"

module mts_seq #(
	parameter int SITES      = mts_pkg::SITES_DEF,
	parameter int NEIGHBOURS = mts_pkg::NEIGHBOURS_DEF,
	parameter int TENSORS    = mts_pkg::TENSORS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mts_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  mts_pkg::item_t                     item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output mts_pkg::res_t                      res,
	output mts_pkg::mem_req_t                  req,
	input  mts_pkg::mem_rsp_t                  rsp,
	output logic signed [mts_pkg::MUL_A_W-1:0] mul_a,
	output logic signed [mts_pkg::MUL_B_W-1:0] mul_b,
	input  logic signed [mts_pkg::MUL_P_W-1:0] prod
);

	localparam int NT_AW    = $clog2(SITES * NEIGHBOURS);
	localparam int TS_AW    = $clog2(TENSORS * mts_pkg::COMPONENTS);
	localparam int SITE_W   = $clog2(SITES);
	localparam int TEN_W    = (TENSORS > 1) ? $clog2(TENSORS) : 1;
	localparam int NB_W     = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
	localparam int SW       = mts_pkg::SPIN_W;
	localparam int PW       = mts_pkg::PROD_SH_W;
	localparam int AW       = mts_pkg::ACC_W;
	localparam int WW       = mts_pkg::WIDE_W;
	localparam int SUMW     = mts_pkg::SUM_W;
	localparam int FB       = mts_pkg::SPIN_FRAC_BITS;
	localparam int U_SHIFT  = FB + 12;
	localparam int D_SPLIT  = (U_SHIFT + 8) / 2;
	localparam int M_LO     = 16;
	localparam int M_W      = 25;

	localparam logic signed [WW-1:0] D_LIM  = 64'sd1 <<< (U_SHIFT + 8);
	localparam logic [WW-1:0]        P_LIM  = 64'd1 << (U_SHIFT + 8);
	localparam logic signed [WW-1:0] DE_MAX = (64'sd1 <<< (mts_pkg::DE_W - 1)) - 64'sd1;
	localparam logic signed [WW-1:0] DE_MIN = -(64'sd1 <<< (mts_pkg::DE_W - 1));
	localparam logic signed [SW-1:0] SPIN_ONE = SW'(1 << FB);
	localparam logic [WW-1:0]        SZ_FULL  = 64'(SITES) << FB;
	localparam logic signed [SUMW-1:0] SZ_RESET = SZ_FULL[SUMW-1:0];

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_RD_OWN, S_OWN_CAP, S_NB_RD, S_NB_CAP, S_SP_CAP,
		S_X0, S_X1, S_X2, S_X3, S_X4, S_NEG, S_F0, S_F1, S_F2,
		S_A0, S_A1, S_A2, S_A3, S_A4, S_DE, S_P0, S_P1, S_P2, S_COMMIT, S_DONE
	} state_t;

	state_t                 state_q;
	logic                   boot_q;
	logic [SITE_W-1:0]      clr_q;
	logic [SITE_W-1:0]      site_q;
	logic signed [SW-1:0]   tx_q, ty_q, tz_q;
	logic signed [SW-1:0]   ox_q, oy_q, oz_q;
	logic signed [SW-1:0]   nx_q, ny_q, nz_q;
	logic [15:0]            rnd_q;
	logic [M_W-1:0]         m_q;
	logic [NB_W-1:0]        k_q;
	logic [1:0]             a_q, b_q, fi_q;
	logic [SITE_W-1:0]      nb_site_q;
	logic [TEN_W-1:0]       nb_ten_q;
	logic signed [PW-1:0]   pt_q, po_q;
	logic signed [AW-1:0]   et_q, eo_q;
	logic signed [WW-1:0]   de_q;
	logic [mts_pkg::MUL_P_W-1:0] pl_q;
	logic                   acc_q;
	logic signed [SUMW-1:0] sx_q, sy_q, sz_q;
	logic                   out_valid_q;
	mts_pkg::res_t          res_q;

	logic                   accept;
	logic                   nt_ok, ts_ok, site_ok;
	logic                   self_nb;
	logic signed [SW-1:0]   nbr_ax, trial_a, trial_b, old_b, trial_f, old_f;
	logic signed [mts_pkg::CFG_W-1:0] fld;
	logic signed [mts_pkg::MUL_P_W-1:0] prod_sh;
	logic [mts_pkg::MUL_P_W-1:0] prod_u;
	logic [WW-1:0]          big;
	logic [7:0]             u_exp;
	logic [15:0]            p_val;
	logic [3:0]             comp_idx;
	logic signed [WW-1:0]   de_out;

	function automatic logic signed [SW-1:0] sel3(input logic [1:0] i,
			input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
			input logic signed [SW-1:0] z);
		logic signed [SW-1:0] v;
		unique case (i)
			2'd0:    v = x;
			2'd1:    v = y;
			default: v = z;
		endcase
		return v;
	endfunction

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign res      = res_q;

	// load range checks
	assign site_ok = (32'(item.site) < SITES);
	assign nt_ok   = site_ok && (32'(item.slot) < NEIGHBOURS) &&
			(32'(item.nbr_site) < SITES) && (32'(item.ten_idx) < TENSORS);
	assign ts_ok   = (32'(item.ten_idx) < TENSORS) && (32'(item.comp) < mts_pkg::COMPONENTS);

	// operand selection
	assign self_nb = (nb_site_q == site_q);
	assign nbr_ax  = sel3(a_q, nx_q, ny_q, nz_q);
	assign trial_a = sel3(a_q, tx_q, ty_q, tz_q);
	assign trial_b = sel3(b_q, tx_q, ty_q, tz_q);
	assign old_b   = sel3(b_q, ox_q, oy_q, oz_q);
	assign trial_f = sel3(fi_q, tx_q, ty_q, tz_q);
	assign old_f   = sel3(fi_q, ox_q, oy_q, oz_q);
	assign fld     = (fi_q == 2'd0) ? cfg.fx : ((fi_q == 2'd1) ? cfg.fy : cfg.fz);
	assign comp_idx = 4'(a_q) * 4'(mts_pkg::AXES) + 4'(b_q);
	assign prod_sh = prod >>> FB;

	// acceptance exponent from the two partial products
	assign prod_u = prod;
	assign big    = (64'(prod_u) << D_SPLIT) + 64'(pl_q);
	assign u_exp  = big[U_SHIFT+7:U_SHIFT];
	assign p_val  = mts_pkg::pow2_frac(u_exp[3:0]) >> u_exp[7:4];

	assign de_out = (de_q > DE_MAX) ? DE_MAX : ((de_q < DE_MIN) ? DE_MIN : de_q);

	// memory requests
	always_comb begin
		req          = '0;
		req.nt_waddr = mts_pkg::NT_MAX_AW'(NT_AW'(SITE_W'(item.site)) * NT_AW'(NEIGHBOURS) +
				NT_AW'(item.slot));
		req.nt_site  = mts_pkg::SITE_MAX_W'(SITE_W'(item.nbr_site));
		req.nt_ten   = mts_pkg::TEN_MAX_W'(TEN_W'(item.ten_idx));
		req.nt_we    = accept && (item.op == mts_pkg::OP_NBR_LOAD) && nt_ok;
		req.nt_raddr = mts_pkg::NT_MAX_AW'(NT_AW'(site_q) * NT_AW'(NEIGHBOURS) + NT_AW'(k_q));
		req.ts_waddr = mts_pkg::TS_MAX_AW'(TS_AW'(TEN_W'(item.ten_idx)) *
				TS_AW'(mts_pkg::COMPONENTS) + TS_AW'(item.comp));
		req.ts_coef  = item.coef;
		req.ts_we    = accept && (item.op == mts_pkg::OP_TEN_LOAD) && ts_ok;
		req.ts_raddr = mts_pkg::TS_MAX_AW'(TS_AW'(nb_ten_q) * TS_AW'(mts_pkg::COMPONENTS) +
				TS_AW'(comp_idx));
		req.sp_raddr = (state_q == S_NB_CAP) ? rsp.nt_site : mts_pkg::SITE_MAX_W'(site_q);
		if (state_q == S_CLEAR) begin
			req.sp_we    = 1'b1;
			req.sp_waddr = mts_pkg::SITE_MAX_W'(clr_q);
			req.sp_wdata = {SW'(0), SW'(0), SPIN_ONE};
		end else begin
			req.sp_we    = (state_q == S_COMMIT) && acc_q;
			req.sp_waddr = mts_pkg::SITE_MAX_W'(site_q);
			req.sp_wdata = {tx_q, ty_q, tz_q};
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_RD_OWN: begin
				mul_a = mts_pkg::MUL_A_W'(cfg.beta);
				mul_b = mts_pkg::MUL_B_W'(mts_pkg::LOG2E_Q16);
			end
			S_X0: begin
				// a slot that names the site itself sees the trial spin
				mul_a = mts_pkg::MUL_A_W'(self_nb ? trial_a : nbr_ax);
				mul_b = mts_pkg::MUL_B_W'(trial_b);
			end
			S_X1: begin
				mul_a = mts_pkg::MUL_A_W'(nbr_ax);
				mul_b = mts_pkg::MUL_B_W'(old_b);
			end
			S_X2: begin
				mul_a = mts_pkg::MUL_A_W'(rsp.ts_coef);
				mul_b = mts_pkg::MUL_B_W'(pt_q);
			end
			S_X3: begin
				mul_a = mts_pkg::MUL_A_W'(rsp.ts_coef);
				mul_b = mts_pkg::MUL_B_W'(po_q);
			end
			S_F0: begin
				mul_a = mts_pkg::MUL_A_W'(fld);
				mul_b = mts_pkg::MUL_B_W'(trial_f);
			end
			S_F1: begin
				mul_a = mts_pkg::MUL_A_W'(fld);
				mul_b = mts_pkg::MUL_B_W'(old_f);
			end
			S_A0: begin
				mul_a = mts_pkg::MUL_A_W'(tz_q);
				mul_b = mts_pkg::MUL_B_W'(tz_q);
			end
			S_A1: begin
				mul_a = mts_pkg::MUL_A_W'(oz_q);
				mul_b = mts_pkg::MUL_B_W'(oz_q);
			end
			S_A2: begin
				mul_a = mts_pkg::MUL_A_W'(cfg.aniso);
				mul_b = mts_pkg::MUL_B_W'(pt_q);
			end
			S_A3: begin
				mul_a = mts_pkg::MUL_A_W'(cfg.aniso);
				mul_b = mts_pkg::MUL_B_W'(po_q);
			end
			S_P0: begin
				mul_a = mts_pkg::MUL_A_W'(m_q);
				mul_b = mts_pkg::MUL_B_W'(de_q[D_SPLIT-1:0]);
			end
			S_P1: begin
				mul_a = mts_pkg::MUL_A_W'(m_q);
				mul_b = mts_pkg::MUL_B_W'(de_q[2*D_SPLIT-1:D_SPLIT]);
			end
			default: ;
		endcase
	end

	// state machine and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			boot_q      <= 1'b1;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			sz_q        <= SZ_RESET;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						site_q <= SITE_W'(item.site);
						tx_q   <= item.tx;
						ty_q   <= item.ty;
						tz_q   <= item.tz;
						rnd_q  <= item.rnd;
						acc_q  <= 1'b0;
						de_q   <= '0;
						k_q    <= '0;
						a_q    <= '0;
						b_q    <= '0;
						et_q   <= '0;
						eo_q   <= '0;
						clr_q  <= '0;
						boot_q <= 1'b0;
						if (item.op == mts_pkg::OP_SPIN_RESET)
							state_q <= S_CLEAR;
						else if (item.op == mts_pkg::OP_TRIAL && site_ok)
							state_q <= S_RD_OWN;
						else
							state_q <= S_DONE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SITE_W'(SITES - 1)) begin
						sx_q    <= '0;
						sy_q    <= '0;
						sz_q    <= SZ_RESET;
						state_q <= boot_q ? S_IDLE : S_DONE;
					end
				end
				S_RD_OWN: state_q <= S_OWN_CAP;
				S_OWN_CAP: begin
					ox_q    <= rsp.sp_data[3*SW-1:2*SW];
					oy_q    <= rsp.sp_data[2*SW-1:SW];
					oz_q    <= rsp.sp_data[SW-1:0];
					m_q     <= prod[M_LO+M_W-1:M_LO];
					state_q <= S_NB_CAP;
				end
				S_NB_RD: state_q <= S_NB_CAP;
				S_NB_CAP: begin
					nb_site_q <= SITE_W'(rsp.nt_site);
					nb_ten_q  <= TEN_W'(rsp.nt_ten);
					state_q   <= S_SP_CAP;
				end
				S_SP_CAP: begin
					// stored spin; for the site itself this is the old spin
					nx_q    <= rsp.sp_data[3*SW-1:2*SW];
					ny_q    <= rsp.sp_data[2*SW-1:SW];
					nz_q    <= rsp.sp_data[SW-1:0];
					state_q <= S_X0;
				end
				S_X0: state_q <= S_X1;
				S_X1: begin
					pt_q    <= prod_sh[PW-1:0];
					state_q <= S_X2;
				end
				S_X2: begin
					po_q    <= prod_sh[PW-1:0];
					state_q <= S_X3;
				end
				S_X3: begin
					et_q    <= mts_pkg::sat_acc(WW'(et_q) + WW'(prod));
					state_q <= S_X4;
				end
				S_X4: begin
					eo_q <= mts_pkg::sat_acc(WW'(eo_q) + WW'(prod));
					if (b_q != 2'd2) begin
						b_q     <= b_q + 1'b1;
						state_q <= S_X0;
					end else if (a_q != 2'd2) begin
						a_q     <= a_q + 1'b1;
						b_q     <= '0;
						state_q <= S_X0;
					end else begin
						a_q <= '0;
						b_q <= '0;
						if (k_q == NB_W'(NEIGHBOURS - 1)) begin
							state_q <= S_NEG;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_NB_RD;
						end
					end
				end
				S_NEG: begin
					et_q    <= -et_q;
					eo_q    <= -eo_q;
					fi_q    <= '0;
					state_q <= S_F0;
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					et_q    <= mts_pkg::sat_acc(WW'(et_q) - WW'(prod));
					state_q <= S_F2;
				end
				S_F2: begin
					eo_q <= mts_pkg::sat_acc(WW'(eo_q) - WW'(prod));
					if (fi_q == 2'd2) begin
						state_q <= S_A0;
					end else begin
						fi_q    <= fi_q + 1'b1;
						state_q <= S_F0;
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: begin
					pt_q    <= prod_sh[PW-1:0];
					state_q <= S_A2;
				end
				S_A2: begin
					po_q    <= prod_sh[PW-1:0];
					state_q <= S_A3;
				end
				S_A3: begin
					et_q    <= mts_pkg::sat_acc(WW'(et_q) - WW'(prod));
					state_q <= S_A4;
				end
				S_A4: begin
					eo_q    <= mts_pkg::sat_acc(WW'(eo_q) - WW'(prod));
					state_q <= S_DE;
				end
				S_DE: begin
					de_q    <= WW'(et_q) - WW'(eo_q);
					state_q <= S_P0;
				end
				S_P0: begin
					// downhill always taken; zero beta gives full-scale probability
					if (de_q <= 0) begin
						acc_q   <= 1'b1;
						state_q <= S_COMMIT;
					end else if (m_q == '0) begin
						acc_q   <= (rnd_q < mts_pkg::pow2_frac(4'd0));
						state_q <= S_COMMIT;
					end else if (de_q >= D_LIM) begin
						acc_q   <= 1'b0;
						state_q <= S_COMMIT;
					end else begin
						state_q <= S_P1;
					end
				end
				S_P1: begin
					pl_q    <= prod;
					state_q <= S_P2;
				end
				S_P2: begin
					acc_q   <= (big < P_LIM) && (rnd_q < p_val);
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (acc_q) begin
						sx_q <= sx_q + SUMW'(tx_q) - SUMW'(ox_q);
						sy_q <= sy_q + SUMW'(ty_q) - SUMW'(oy_q);
						sz_q <= sz_q + SUMW'(tz_q) - SUMW'(oz_q);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						res_q.accepted <= acc_q;
						res_q.de       <= de_out[mts_pkg::DE_W-1:0];
						res_q.sx       <= sx_q;
						res_q.sy       <= sy_q;
						res_q.sz       <= sz_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle right after accepting a word")
	`MTS_ASSERT_IMP(a_spin_write_src, req.sp_we, state_q == S_CLEAR || (state_q == S_COMMIT && acc_q), "spin write outside sweep or commit")
	`MTS_ASSERT_IMP(a_out_from_done, out_valid_q && !$past(out_valid_q), $past(state_q) == S_DONE, "result word loaded outside done")

endmodule

/* sv/metropolis_tensor_spin_update.sv */
// Top level of the Metropolis tensor spin update block: configuration registers
// and the sequencer, memories and shared multiplier. Depends on mts_pkg, mts_mac,
// mts_store and mts_seq.
`timescale 1ns / 1ps

// One word in, one word out. A spin reset sweeps the spin store one site a cycle;
// the same sweep runs after reset, with in_stall high until it ends. A trial walks
// every neighbour slot on a single shared 26x19 multiplier: per slot it reads the
// neighbour table and the neighbour's spin, then for each tensor element multiplies
// the coefficient into the trial and old spin products; then come the field,
// anisotropy and acceptance steps. in_stall stays high while a word is in work.
module metropolis_tensor_spin_update #(
	parameter int SITES      = mts_pkg::SITES_DEF,
	parameter int NEIGHBOURS = mts_pkg::NEIGHBOURS_DEF,
	parameter int TENSORS    = mts_pkg::TENSORS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             op,
	input  logic [11:0]                            site,
	input  logic [4:0]                             slot,
	input  logic [11:0]                            neighbour_site,
	input  logic [4:0]                             tensor_index,
	input  logic [3:0]                             component,
	input  logic signed [23:0]                     coefficient,
	input  logic signed [15:0]                     trial_x,
	input  logic signed [15:0]                     trial_y,
	input  logic signed [15:0]                     trial_z,
	input  logic [15:0]                            uniform_random,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   accepted,
	output logic signed [47:0]                     energy_change,
	output logic signed [27:0]                     sum_x,
	output logic signed [27:0]                     sum_y,
	output logic signed [27:0]                     sum_z,
	input  logic                                   cfg_we,
	input  logic [mts_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mts_pkg::CFG_W-1:0]              cfg_data
);

	mts_pkg::cfg_t     cfg_q;
	mts_pkg::item_t    item;
	mts_pkg::res_t     res;
	mts_pkg::mem_req_t req;
	mts_pkg::mem_rsp_t rsp;
	logic signed [mts_pkg::MUL_A_W-1:0] mul_a;
	logic signed [mts_pkg::MUL_B_W-1:0] mul_b;
	logic signed [mts_pkg::MUL_P_W-1:0] prod_s1;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mts_pkg::CFG_BETA:    cfg_q.beta  <= cfg_data;
				mts_pkg::CFG_FIELD_X: cfg_q.fx    <= cfg_data;
				mts_pkg::CFG_FIELD_Y: cfg_q.fy    <= cfg_data;
				mts_pkg::CFG_FIELD_Z: cfg_q.fz    <= cfg_data;
				mts_pkg::CFG_ANISO:   cfg_q.aniso <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word
	assign item.op       = op;
	assign item.site     = site;
	assign item.slot     = slot;
	assign item.nbr_site = neighbour_site;
	assign item.ten_idx  = tensor_index;
	assign item.comp     = component;
	assign item.coef     = coefficient;
	assign item.tx       = trial_x;
	assign item.ty       = trial_y;
	assign item.tz       = trial_z;
	assign item.rnd      = uniform_random;

	// result word
	assign accepted      = res.accepted;
	assign energy_change = res.de;
	assign sum_x         = res.sx;
	assign sum_y         = res.sy;
	assign sum_z         = res.sz;

	mts_seq #(
		.SITES      (SITES),
		.NEIGHBOURS (NEIGHBOURS),
		.TENSORS    (TENSORS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.item      (item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.req       (req),
		.rsp       (rsp),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.prod      (prod_s1)
	);

	mts_store #(
		.SITES      (SITES),
		.NEIGHBOURS (NEIGHBOURS),
		.TENSORS    (TENSORS)
	) u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	mts_mac u_mac (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

endmodule

/* dv/metropolis_tensor_spin_update_tb.sv */
// Testbench for metropolis_tensor_spin_update: directed table, then random phases,
// each result checked against a predictor of the spin update or a fixed expected word. Depends on mts_pkg.
`timescale 1ns / 1ps

module metropolis_tensor_spin_update_tb;

	localparam int N_SITES    = 4096;
	localparam int N_SLOTS    = 32;
	localparam int N_TENSORS  = 32;
	localparam int FRAC       = 14;
	localparam int STALL_LIMIT = 40000;
	localparam int ITEMS_PER_PHASE = 115;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] op;
	logic [11:0] site, neighbour_site;
	logic [4:0] slot, tensor_index;
	logic [3:0] component;
	logic signed [23:0] coefficient;
	logic signed [15:0] trial_x, trial_y, trial_z;
	logic [15:0] uniform_random;
	logic accepted;
	logic signed [47:0] energy_change;
	logic signed [27:0] sum_x, sum_y, sum_z;
	logic cfg_we;
	logic [mts_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mts_pkg::CFG_W-1:0] cfg_data;

	metropolis_tensor_spin_update DUT (.*);

	// predictor state
	int spin_now[N_SITES][3];
	int nbr_of[N_SITES*N_SLOTS];
	int sel_of[N_SITES*N_SLOTS];
	int coef_of[N_TENSORS*9];
	logic [31:0] slots_loaded[N_SITES];
	longint mag_sum[3];
	longint beta_q, fld[3], aniso_k;
	int ready_sites[$];

	mts_pkg::res_t expected_words[$];
	int errors = 0;
	int idle_in = 0;
	int idle_out = 0;
	int quiet_cycles = 0;

	typedef struct {
		mts_pkg::item_t w;
		bit             typed;
		mts_pkg::res_t  r;
	} row_t;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint wrap28(longint v);
		logic signed [27:0] t;
		t = v[27:0];
		return longint'(t);
	endfunction

	function automatic longint clamp61(longint a, longint b);
		longint r;
		r = a + b;
		if (r > (64'sd1 <<< 61)) r = 64'sd1 <<< 61;
		if (r < -(64'sd1 <<< 61)) r = -(64'sd1 <<< 61);
		return r;
	endfunction

	function automatic void spins_home();
		for (int i = 0; i < N_SITES; i++) begin
			spin_now[i][0] = 0;
			spin_now[i][1] = 0;
			spin_now[i][2] = 1 << FRAC;
		end
		mag_sum[0] = 0;
		mag_sum[1] = 0;
		mag_sum[2] = wrap28(longint'(N_SITES) << FRAC);
	endfunction

	// energy of one site holding spin s
	function automatic longint site_energy(int st, int s[3]);
		longint ex, e, p;
		int idx, nb, t;
		int ns[3];
		ex = 0;
		for (int k = 0; k < N_SLOTS; k++) begin
			idx = st * N_SLOTS + k;
			nb = nbr_of[idx];
			t = sel_of[idx];
			for (int a = 0; a < 3; a++)
				ns[a] = (nb == st) ? s[a] : spin_now[nb][a];
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++) begin
					p = (longint'(ns[a]) * longint'(s[b])) >>> FRAC;
					ex = clamp61(ex, longint'(coef_of[t*9 + 3*a + b]) * p);
				end
		end
		e = -ex;
		for (int a = 0; a < 3; a++)
			e = clamp61(e, -(fld[a] * longint'(s[a])));
		e = clamp61(e, -(aniso_k * ((longint'(s[2]) * longint'(s[2])) >>> FRAC)));
		return e;
	endfunction

	// acceptance threshold from the exp table
	function automatic int accept_threshold(longint unsigned d);
		longint unsigned m, lim, u;
		m = (longint'(beta_q) * 94548) >> 16;
		if (m == 0)
			u = 0;
		else begin
			lim = (longint'(256) << 26) / m;
			u = (d > lim) ? 256 : ((d * m) >> 26);
		end
		if (u >= 256) return 0;
		return int'(mts_pkg::pow2_frac(u[3:0])) >> u[7:4];
	endfunction

	function automatic bit site_ready(int st);
		foreach (ready_sites[i])
			if (ready_sites[i] == st) return 1;
		return 0;
	endfunction

	// state update and expected word for one accepted input word
	function automatic mts_pkg::res_t spin_update(mts_pkg::item_t w);
		mts_pkg::res_t r;
		int trial[3];
		longint de, dsat;
		r = '0;
		case (mts_pkg::op_t'(w.op))
			mts_pkg::OP_NBR_LOAD: begin
				nbr_of[w.site*N_SLOTS + w.slot] = w.nbr_site;
				sel_of[w.site*N_SLOTS + w.slot] = w.ten_idx;
				slots_loaded[w.site][w.slot] = 1'b1;
				if (&slots_loaded[w.site] && !site_ready(w.site))
					ready_sites.push_back(w.site);
			end
			mts_pkg::OP_TEN_LOAD: begin
				if (w.comp < 9) coef_of[w.ten_idx*9 + w.comp] = w.coef;
			end
			mts_pkg::OP_SPIN_RESET: spins_home();
			mts_pkg::OP_TRIAL: begin
				trial[0] = w.tx;
				trial[1] = w.ty;
				trial[2] = w.tz;
				de = site_energy(w.site, trial) - site_energy(w.site, spin_now[w.site]);
				if (de <= 0 || int'(w.rnd) < accept_threshold(longint'(de))) begin
					r.accepted = 1'b1;
					for (int i = 0; i < 3; i++) begin
						mag_sum[i] = wrap28(mag_sum[i] + trial[i] - spin_now[w.site][i]);
						spin_now[w.site][i] = trial[i];
					end
				end
				dsat = de;
				if (dsat > (64'sd1 <<< 47) - 1) dsat = (64'sd1 <<< 47) - 1;
				if (dsat < -(64'sd1 <<< 47)) dsat = -(64'sd1 <<< 47);
				r.de = dsat[47:0];
			end
		endcase
		r.sx = mag_sum[0][27:0];
		r.sy = mag_sum[1][27:0];
		r.sz = mag_sum[2][27:0];
		return r;
	endfunction

	// drive one word and wait for it to be taken
	task automatic send_word(mts_pkg::item_t w, bit typed, mts_pkg::res_t r);
		mts_pkg::res_t p;
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op <= w.op;
		site <= w.site;
		slot <= w.slot;
		neighbour_site <= w.nbr_site;
		tensor_index <= w.ten_idx;
		component <= w.comp;
		coefficient <= w.coef;
		trial_x <= w.tx;
		trial_y <= w.ty;
		trial_z <= w.tz;
		uniform_random <= w.rnd;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		p = spin_update(w);
		expected_words.push_back(typed ? r : p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all five registers while idle
	task automatic set_regs(logic [23:0] b, logic [23:0] x, logic [23:0] y,
			logic [23:0] z, logic [23:0] k);
		logic [23:0] v[5];
		v = '{b, x, y, z, k};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= mts_pkg::CFG_IDX_W'(i);
			cfg_data <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		beta_q = b;
		fld[0] = longint'($signed(x));
		fld[1] = longint'($signed(y));
		fld[2] = longint'($signed(z));
		aniso_k = longint'($signed(k));
	endtask

	function automatic logic signed [15:0] rand_spin();
		int c;
		c = $urandom_range(99);
		if (c < 30) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
		if (c < 90) return 16'($signed($urandom_range(32768)) - 16384);
		return 16'($urandom);
	endfunction

	function automatic logic signed [23:0] rand_coef();
		if ($urandom_range(19) == 0) return 24'($urandom);
		return 24'($signed($urandom_range(4000)) - 2000);
	endfunction

	function automatic mts_pkg::item_t rand_word();
		mts_pkg::item_t w;
		int c;
		w = '0;
		w.rnd = 16'($urandom);
		c = $urandom_range(99);
		if (c < 44) begin
			w.op = mts_pkg::OP_TRIAL;
			w.site = 12'(ready_sites[$urandom_range(ready_sites.size() - 1)]);
			w.tx = rand_spin();
			w.ty = rand_spin();
			w.tz = rand_spin();
			if ($urandom_range(3) == 0) begin
				w.tx = 0;
				w.ty = 0;
			end
		end else if (c < 70) begin
			w.op = mts_pkg::OP_NBR_LOAD;
			w.site = ($urandom_range(1)) ?
				12'(ready_sites[$urandom_range(ready_sites.size() - 1)]) : 12'($urandom);
			w.slot = 5'($urandom);
			w.nbr_site = 12'($urandom);
			w.ten_idx = 5'($urandom);
		end else if (c < 99) begin
			w.op = mts_pkg::OP_TEN_LOAD;
			w.ten_idx = 5'($urandom);
			w.comp = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
			w.coef = rand_coef();
		end else
			w.op = mts_pkg::OP_SPIN_RESET;
		w.nbr_site = (w.op == mts_pkg::OP_NBR_LOAD) ? w.nbr_site : 12'($urandom);
		return w;
	endfunction

	// result checker, stall generator and watchdog
	always @(posedge clk) begin
		mts_pkg::res_t e;
		out_stall <= ($urandom_range(99) < idle_out);
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("metropolis_tensor_spin_update test failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
		if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (accepted !== e.accepted) begin
					$error("accepted exp %0d got %0d", e.accepted, accepted);
					errors++;
				end
				if (energy_change !== e.de) begin
					$error("energy_change exp %0d got %0d", e.de, energy_change);
					errors++;
				end
				if (sum_x !== e.sx) begin
					$error("sum_x exp %0d got %0d", e.sx, sum_x);
					errors++;
				end
				if (sum_y !== e.sy) begin
					$error("sum_y exp %0d got %0d", e.sy, sum_y);
					errors++;
				end
				if (sum_z !== e.sz) begin
					$error("sum_z exp %0d got %0d", e.sz, sum_z);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		mts_pkg::item_t w;
		mts_pkg::res_t home, none;
		int setup_sites[$];

		arst_n = 1'b0;
		in_valid = 1'b0;
		{op, site, slot, neighbour_site, tensor_index, component} = '0;
		{coefficient, trial_x, trial_y, trial_z, uniform_random} = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < N_SITES*N_SLOTS; i++) begin
			nbr_of[i] = 0;
			sel_of[i] = 0;
		end
		for (int i = 0; i < N_SITES; i++) slots_loaded[i] = '0;
		for (int i = 0; i < N_TENSORS*9; i++) coef_of[i] = 0;
		spins_home();
		beta_q = 0;
		fld = '{0, 0, 0};
		aniso_k = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs('0, '0, '0, '0, '0);

		// fill every tensor, then every slot of a handful of sites
		none = '0;
		for (int t = 0; t < N_TENSORS; t++)
			for (int c = 0; c < 9; c++) begin
				w = '0;
				w.op = mts_pkg::OP_TEN_LOAD;
				w.ten_idx = 5'(t);
				w.comp = 4'(c);
				w.coef = rand_coef();
				send_word(w, 0, none);
			end
		setup_sites = '{0, 1, 2, 4095};
		repeat (8) setup_sites.push_back($urandom_range(4095));
		foreach (setup_sites[i])
			for (int k = 0; k < N_SLOTS; k++) begin
				w = '0;
				w.op = mts_pkg::OP_NBR_LOAD;
				w.site = 12'(setup_sites[i]);
				w.slot = 5'(k);
				w.nbr_site = (k == 3) ? 12'(setup_sites[i]) : 12'($urandom);
				w.ten_idx = 5'($urandom);
				send_word(w, 0, none);
			end

		// directed table
		home = '0;
		home.sz = 28'(N_SITES << FRAC);
		w = '0; w.op = mts_pkg::OP_SPIN_RESET;
		rows.push_back('{w, 1, home});
		w = '0; w.op = mts_pkg::OP_TEN_LOAD; w.comp = 4'd15; w.coef = 24'sh7FFFFF;
		rows.push_back('{w, 1, home});
		w = '0; w.op = mts_pkg::OP_TEN_LOAD; w.ten_idx = 5'd31; w.comp = 4'd8;
		w.coef = 24'sh800000;
		rows.push_back('{w, 1, home});
		w = '0; w.op = mts_pkg::OP_TEN_LOAD; w.comp = 4'd0; w.coef = 24'sh7FFFFF;
		rows.push_back('{w, 1, home});
		w = '0; w.op = mts_pkg::OP_NBR_LOAD; w.site = 12'hFFF; w.slot = 5'd31;
		w.nbr_site = 12'hFFF; w.ten_idx = 5'd31;
		rows.push_back('{w, 1, home});
		w = '0; w.op = mts_pkg::OP_NBR_LOAD; w.slot = 5'd0; w.nbr_site = 12'hFFF;
		w.ten_idx = 5'd0;
		rows.push_back('{w, 1, home});
		w = '0; w.op = mts_pkg::OP_TRIAL; w.tz = 16'sd16384; w.rnd = 16'd0;
		rows.push_back('{w, 0, none});
		w = '0; w.op = mts_pkg::OP_TRIAL; w.tx = 16'sd16384; w.rnd = 16'hFFFF;
		rows.push_back('{w, 0, none});
		w = '0; w.op = mts_pkg::OP_TRIAL; w.site = 12'hFFF; w.tx = -16'sd16384;
		w.rnd = 16'd0;
		rows.push_back('{w, 0, none});
		w = '0; w.op = mts_pkg::OP_TRIAL; w.site = 12'd1; w.tz = -16'sd16384;
		w.rnd = 16'hFFFF;
		rows.push_back('{w, 0, none});
		// trial far from unit length
		w = '0; w.op = mts_pkg::OP_TRIAL; w.site = 12'd2; w.tx = 16'sh7FFF; w.ty = 16'sh8000;
		w.rnd = 16'h8000;
		rows.push_back('{w, 0, none});
		w = '0; w.op = mts_pkg::OP_TRIAL; w.site = 12'hFFF; w.ty = 16'sd16384;
		w.rnd = 16'hFFFF;
		rows.push_back('{w, 0, none});
		w = '0; w.op = mts_pkg::OP_TRIAL; w.tz = 16'sd16384; w.rnd = 16'h7FFF;
		rows.push_back('{w, 0, none});
		w = '0; w.op = mts_pkg::OP_SPIN_RESET;
		rows.push_back('{w, 1, home});
		foreach (rows[i]) begin
			rw = rows[i];
			send_word(rw.w, rw.typed, rw.r);
		end
		drain();

		// random phases: (sender idle, receiver stall) and register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_in = 0;  idle_out = 0;
					set_regs(24'd300, 24'd1000, -24'sd1000, 24'd5000, 24'd200); end
				1: begin idle_in = 88; idle_out = 0;
					set_regs(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF); end
				2: begin idle_in = 0;  idle_out = 88;
					set_regs(24'd0, 24'h800000, 24'h800000, 24'h800000, 24'h800000); end
				3: begin idle_in = 34; idle_out = 34;
					set_regs(24'($urandom_range(4096)), 24'($urandom), 24'($urandom),
						24'($urandom), 24'($urandom)); end
				default: begin idle_in = 0; idle_out = 0;
					set_regs(24'd1, 24'd0, 24'd0, -24'sd3000, -24'sd500); end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off until the block is empty once
				if (ph == 3 && n == ITEMS_PER_PHASE / 2) begin
					in_valid <= 1'b0;
					while (expected_words.size() != 0) @(posedge clk);
				end
				send_word(rand_word(), 0, none);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("metropolis_tensor_spin_update test passed");
		else
			$display("metropolis_tensor_spin_update test failed");
		$finish;
	end

endmodule

/* metropolis_tensor_spin_update.f */
+incdir+sv
sv/mts_pkg.sv
sv/mts_mac.sv
sv/mts_store.sv
sv/mts_seq.sv
sv/metropolis_tensor_spin_update.sv
dv/metropolis_tensor_spin_update_tb.sv
